@@ sv/stb_pkg.sv @@
// ----------------------------------------------------------------------------
// stb_pkg
// Shared types, codes and character classes for the source byte tokenizer.
// ----------------------------------------------------------------------------
package stb_pkg;

  localparam int CH_W      = 8;
  localparam int KIND_W    = 4;
  localparam int SPAN_W    = 16;
  localparam int RUN_MAX   = 3;
  localparam int RUN_CNT_W = 2;
  localparam int ASCII_N   = 128;

  // scanner modes, one-hot
  typedef enum logic [6:0] {
    M_IDLE    = 7'b0000001,
    M_IDENT   = 7'b0000010,
    M_STRING  = 7'b0000100,
    M_SLASH   = 7'b0001000,
    M_COMMENT = 7'b0010000,
    M_HALTED  = 7'b0100000,
    M_DONE    = 7'b1000000
  } mode_t;

  // token kinds
  localparam logic [KIND_W-1:0] K_IDENT     = 4'd0;
  localparam logic [KIND_W-1:0] K_COLON     = 4'd1;
  localparam logic [KIND_W-1:0] K_COMMA     = 4'd2;
  localparam logic [KIND_W-1:0] K_EQUAL     = 4'd3;
  localparam logic [KIND_W-1:0] K_LBRACE    = 4'd4;
  localparam logic [KIND_W-1:0] K_LPAREN    = 4'd5;
  localparam logic [KIND_W-1:0] K_RBRACE    = 4'd6;
  localparam logic [KIND_W-1:0] K_RPAREN    = 4'd7;
  localparam logic [KIND_W-1:0] K_SEMICOLON = 4'd8;
  localparam logic [KIND_W-1:0] K_STRLIT    = 4'd9;
  localparam logic [KIND_W-1:0] K_EOF       = 4'd10;
  localparam logic [KIND_W-1:0] K_BAD       = 4'd11;
  localparam logic [KIND_W-1:0] K_UNTERM    = 4'd12;
  localparam logic [KIND_W-1:0] K_NOTE      = 4'd13;

  // characters
  localparam logic [CH_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CH_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CH_W-1:0] CH_LF     = 8'h0A;
  localparam logic [CH_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CH_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [CH_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CH_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [CH_W-1:0] CH_USCORE = 8'h5F;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SPAN_W-1:0] span_start;
    logic [SPAN_W-1:0] span_end;
    logic [SPAN_W-1:0] literal_length;
    logic [SPAN_W-1:0] literal_number;
  } result_t;

  function automatic logic is_letter(input logic [CH_W-1:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_USCORE;
  endfunction

  function automatic logic is_digit(input logic [CH_W-1:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [CH_W-1:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
  endfunction

  // punctuation kind, K_IDENT when the byte is no punctuation mark
  function automatic logic [KIND_W-1:0] punct_kind(input logic [CH_W-1:0] c);
    logic [KIND_W-1:0] k;
    unique case (c)
      8'h3A:   k = K_COLON;
      8'h2C:   k = K_COMMA;
      8'h3D:   k = K_EQUAL;
      8'h7B:   k = K_LBRACE;
      8'h28:   k = K_LPAREN;
      8'h7D:   k = K_RBRACE;
      8'h29:   k = K_RPAREN;
      8'h3B:   k = K_SEMICOLON;
      default: k = K_IDENT;
    endcase
    return k;
  endfunction

endpackage

@@ sv/stb_scan.sv @@
// ----------------------------------------------------------------------------
// stb_scan
// Scanner state and single-pass decode of one source byte into a run of up
// to three results.
// ----------------------------------------------------------------------------
module stb_scan #(
  parameter int POS_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   step,
  input  logic [stb_pkg::CH_W-1:0]               ch,
  output stb_pkg::result_t                       run [stb_pkg::RUN_MAX],
  output logic [stb_pkg::RUN_CNT_W-1:0]          run_cnt
);
  import stb_pkg::*;

  mode_t                 mode_r, mode_nxt;
  logic [POS_BITS-1:0]   pos_r, pos_nxt;
  logic [POS_BITS-1:0]   tb_r, tb_nxt;
  logic [SPAN_W-1:0]     slen_r, slen_nxt;
  logic [SPAN_W-1:0]     lnum_r, lnum_nxt;
  logic [ASCII_N-1:0]    seen_r, seen_nxt;
  logic                  any_bad_r, any_bad_nxt;

  logic [POS_BITS-1:0]   pos_inc, tb_inc;
  logic [KIND_W-1:0]     pk;
  logic [6:0]            ch_idx;
  logic                  tail, end_line, bad_class;
  logic                  do_idle, pre_v, a_v, b_v;
  result_t               pre, a, b;

  function automatic result_t mk(input logic [KIND_W-1:0] k,
                                 input logic [POS_BITS-1:0] s,
                                 input logic [POS_BITS-1:0] e,
                                 input logic [SPAN_W-1:0] len,
                                 input logic [SPAN_W-1:0] num);
    result_t r;
    r.kind           = k;
    r.span_start     = SPAN_W'(s);
    r.span_end       = SPAN_W'(e);
    r.literal_length = len;
    r.literal_number = num;
    return r;
  endfunction

  assign pos_inc   = pos_r + 1'b1;
  assign tb_inc    = tb_r + 1'b1;
  assign pk        = punct_kind(ch);
  assign ch_idx    = ch[6:0];
  assign tail      = is_letter(ch) || is_digit(ch);
  assign end_line  = (ch == CH_LF) || (ch == CH_NUL);
  assign bad_class = !ch[7] && ch != CH_NUL && !is_letter(ch) && pk == K_IDENT &&
                     ch != CH_QUOTE && ch != CH_SLASH && !is_space(ch);

  always_comb begin
    mode_nxt    = mode_r;
    pos_nxt     = pos_r;
    tb_nxt      = tb_r;
    slen_nxt    = slen_r;
    lnum_nxt    = lnum_r;
    seen_nxt    = seen_r;
    any_bad_nxt = any_bad_r;
    do_idle     = 1'b0;
    pre_v       = 1'b0;
    a_v         = 1'b0;
    b_v         = 1'b0;
    pre         = '0;
    a           = '0;
    b           = '0;

    unique case (mode_r)
      M_IDENT: begin
        if (tail) begin
          pos_nxt = pos_inc;
        end else begin
          pre_v   = 1'b1;
          pre     = mk(K_IDENT, tb_r, pos_r, '0, '0);
          do_idle = 1'b1;
        end
      end
      M_SLASH: begin
        if (ch == CH_SLASH) begin
          mode_nxt = M_COMMENT;
          pos_nxt  = pos_inc;
        end else begin
          // lone slash is a bad character at its own offset
          if (!seen_r[CH_SLASH[6:0]]) begin
            pre_v                  = 1'b1;
            pre                    = mk(K_BAD, tb_r, tb_inc, '0, '0);
            seen_nxt[CH_SLASH[6:0]] = 1'b1;
            any_bad_nxt            = 1'b1;
          end
          do_idle = 1'b1;
        end
      end
      M_COMMENT: begin
        if (end_line) begin
          do_idle = 1'b1;
        end else begin
          pos_nxt = pos_inc;
        end
      end
      M_STRING: begin
        if (ch == CH_QUOTE) begin
          a_v      = 1'b1;
          a        = mk(K_STRLIT, tb_r, pos_inc, slen_r, lnum_r);
          lnum_nxt = lnum_r + 1'b1;
          mode_nxt = M_IDLE;
          pos_nxt  = pos_inc;
        end else if (end_line) begin
          a_v      = 1'b1;
          a        = mk(K_UNTERM, tb_r, pos_r, '0, '0);
          mode_nxt = M_HALTED;
        end else begin
          if (ch != CH_BSLASH) begin
            slen_nxt = slen_r + 1'b1;
          end
          pos_nxt = pos_inc;
        end
      end
      M_IDLE: begin
        do_idle = 1'b1;
      end
      M_HALTED, M_DONE: begin
      end
      default: begin
      end
    endcase

    if (do_idle) begin
      mode_nxt = M_IDLE;
      pos_nxt  = pos_inc;
      priority if (is_letter(ch)) begin
        mode_nxt = M_IDENT;
        tb_nxt   = pos_r;
      end else if (pk != K_IDENT) begin
        a_v = 1'b1;
        a   = mk(pk, pos_r, pos_inc, '0, '0);
      end else if (ch == CH_QUOTE) begin
        mode_nxt = M_STRING;
        tb_nxt   = pos_r;
        slen_nxt = '0;
      end else if (ch == CH_SLASH) begin
        mode_nxt = M_SLASH;
        tb_nxt   = pos_r;
      end else if (is_space(ch)) begin
      end else if (ch == CH_NUL) begin
        a_v      = 1'b1;
        a        = mk(K_EOF, pos_r, pos_inc, '0, '0);
        b_v      = any_bad_nxt;
        b        = mk(K_NOTE, '0, '0, '0, '0);
        mode_nxt = M_DONE;
      end else if (bad_class) begin
        if (!seen_r[ch_idx]) begin
          a_v              = 1'b1;
          a                = mk(K_BAD, pos_r, pos_inc, '0, '0);
          seen_nxt[ch_idx] = 1'b1;
          any_bad_nxt      = 1'b1;
        end
      end else begin
        // high bytes are dropped
      end
    end
  end

  // pack the run in order: leading result, then the idle-scan results
  always_comb begin
    run[0]  = '0;
    run[1]  = '0;
    run[2]  = '0;
    run_cnt = RUN_CNT_W'({1'b0, pre_v} + {1'b0, a_v} + {1'b0, b_v});
    if (pre_v) begin
      run[0] = pre;
      run[1] = a;
      run[2] = b;
    end else if (a_v) begin
      run[0] = a;
      run[1] = b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= M_IDLE;
      pos_r     <= '0;
      tb_r      <= '0;
      slen_r    <= '0;
      lnum_r    <= '0;
      seen_r    <= '0;
      any_bad_r <= 1'b0;
    end else if (step) begin
      mode_r    <= mode_nxt;
      pos_r     <= pos_nxt;
      tb_r      <= tb_nxt;
      slen_r    <= slen_nxt;
      lnum_r    <= lnum_nxt;
      seen_r    <= seen_nxt;
      any_bad_r <= any_bad_nxt;
    end
  end

  // once finished the scanner stays finished
  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == M_DONE |=> mode_r == M_DONE)
    else $error("scanner left done mode");

  // a three-result run always ends in the note
  a_three_note: assert property (@(posedge clk) disable iff (!rst_n)
    step && run_cnt == 2'd3 |-> run[2].kind == K_NOTE)
    else $error("three-result run without trailing note");

  // the bad flag only rises on a step that reported something
  a_bad_reported: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(any_bad_r) |-> $past(step && run_cnt != '0))
    else $error("bad flag set without a report");

endmodule

@@ sv/stb_runbuf.sv @@
// ----------------------------------------------------------------------------
// stb_runbuf
// Result register holding the run of one item and draining it one result
// per cycle toward the output channel while out_stall is low.
// ----------------------------------------------------------------------------
module stb_runbuf (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              out_stall,
  input  stb_pkg::result_t                  run [stb_pkg::RUN_MAX],
  input  logic [stb_pkg::RUN_CNT_W-1:0]     run_cnt,
  output logic                              load,
  output logic                              can_load,
  output logic                              out_valid,
  output stb_pkg::result_t                  out_res,
  output logic                              out_last
);
  import stb_pkg::*;

  result_t                slot_r [RUN_MAX];
  logic [RUN_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                   pop;

  assign out_valid = cnt_r != '0;
  assign out_res   = slot_r[0];
  assign out_last  = cnt_r == RUN_CNT_W'(1);
  assign pop       = out_valid && !out_stall;
  // take a new item once the buffer empties in this cycle
  assign can_load  = (cnt_r == '0) || (cnt_r == RUN_CNT_W'(1) && !out_stall);
  assign load      = in_valid && can_load;

  always_comb begin
    cnt_nxt = cnt_r;
    if (load) begin
      cnt_nxt = run_cnt;
    end else if (pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot_r[0] <= run[0];
      slot_r[1] <= run[1];
      slot_r[2] <= run[2];
    end else if (pop) begin
      slot_r[0] <= slot_r[1];
      slot_r[1] <= slot_r[2];
    end
  end

  // a new run never overwrites results still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (cnt_r == '0) || (cnt_r == RUN_CNT_W'(1) && pop))
    else $error("run loaded over pending results");

  // a pop without a load drops exactly one result
  a_pop_one: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !load |=> cnt_r == $past(cnt_r) - 1'b1)
    else $error("drain count slip");

  // count never exceeds the longest run
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= RUN_CNT_W'(RUN_MAX))
    else $error("result count out of range");

endmodule

@@ sv/source_byte_tokenizer.sv @@
// ----------------------------------------------------------------------------
// source_byte_tokenizer
// Byte-serial tokenizer: identifiers, punctuation, string literals, errors.
// ----------------------------------------------------------------------------
// usage:
//   in_ch takes one source byte per item at successive offsets; 0 ends the
//   source. each item gives a run of zero to three results on the out_
//   channel, the final one of a run flagged by out_last_of_run.
// latency: the results of an item are presented from the cycle after it is
//   accepted, one result per cycle while out_stall is low.
// throughput: one item per cycle while runs hold at most one result and
//   out_stall is low; an item with a longer run holds the input until the
//   single result register is passing on the last result of the run.
// stall: while out_stall is high the waiting result holds; in_stall rises
//   once the pending run cannot drain in the current cycle.
// reset: rst_n clears the scanner to idle, the position and literal counters
//   to zero and the bad-character table directly; no clearing pass.
// after an end of source or an unterminated string the block accepts items
//   and gives no more results until reset.
// ----------------------------------------------------------------------------
module source_byte_tokenizer #(
  parameter int POS_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [stb_pkg::CH_W-1:0]      in_ch,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [stb_pkg::KIND_W-1:0]    out_tok_kind,
  output logic [stb_pkg::SPAN_W-1:0]    out_span_start,
  output logic [stb_pkg::SPAN_W-1:0]    out_span_end,
  output logic [stb_pkg::SPAN_W-1:0]    out_literal_length,
  output logic [stb_pkg::SPAN_W-1:0]    out_literal_number,
  output logic                          out_last_of_run
);
  import stb_pkg::*;

  result_t                run [RUN_MAX];
  logic [RUN_CNT_W-1:0]   run_cnt;
  logic                   load, can_load;
  result_t                out_res;

  stb_scan #(
    .POS_BITS (POS_BITS)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (load),
    .ch      (in_ch),
    .run     (run),
    .run_cnt (run_cnt)
  );

  stb_runbuf u_runbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .run       (run),
    .run_cnt   (run_cnt),
    .load      (load),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_res   (out_res),
    .out_last  (out_last_of_run)
  );

  assign in_stall           = !can_load;
  assign out_tok_kind       = out_res.kind;
  assign out_span_start     = out_res.span_start;
  assign out_span_end       = out_res.span_end;
  assign out_literal_length = out_res.literal_length;
  assign out_literal_number = out_res.literal_number;

endmodule
